// ===== src/clnw_pkg.sv =====
// ----------------------------------------------------------------------------
// clnw_pkg: shared types and constants for the character LCD nibble writer
// Register indexes, action codes, job format and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package clnw_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_LINE_COUNT       = 3'd0,
      REG_CONTROLLER_KIND  = 3'd1,
      REG_WRAP_ENABLE      = 3'd2,
      REG_FIRST_LINE_BASE  = 3'd3,
      REG_SECOND_LINE_BASE = 3'd4,
      REG_THIRD_LINE_BASE  = 3'd5,
      REG_FOURTH_LINE_BASE = 3'd6,
      REG_LINE_LENGTH      = 3'd7
   } csr_index_type;

   // request actions
   typedef enum logic [1:0] {
      ACT_PUT     = 2'd0,
      ACT_COMMAND = 2'd1,
      ACT_DATA    = 2'd2,
      ACT_GOTO    = 2'd3
   } action_type;

   localparam int CSR_DATA_WIDTH = 7;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic       RS_INSTR     = 1'b0;
   localparam logic       RS_DATA      = 1'b1;

   // register reset values
   localparam logic [2:0] LINE_COUNT_RESET       = 3'd2;
   localparam logic       CONTROLLER_KIND_RESET  = 1'b0;
   localparam logic       WRAP_ENABLE_RESET      = 1'b0;
   localparam logic [6:0] FIRST_LINE_BASE_RESET  = 7'd0;
   localparam logic [6:0] SECOND_LINE_BASE_RESET = 7'd64;
   localparam logic [6:0] THIRD_LINE_BASE_RESET  = 7'd20;
   localparam logic [6:0] FOURTH_LINE_BASE_RESET = 7'd84;
   localparam logic [6:0] LINE_LENGTH_RESET      = 7'd20;

   // configuration as seen by the front end
   typedef struct packed {
      logic [2:0] line_count;
      logic       controller_kind;
      logic       wrap_enable;
      logic [6:0] first_line_base;
      logic [6:0] second_line_base;
      logic [6:0] third_line_base;
      logic [6:0] fourth_line_base;
      logic [6:0] line_length;
   } cfg_type;

   // one job: one or two bytes; a single-byte job uses byte0 only
   typedef struct packed {
      logic       two;
      logic [7:0] byte0;
      logic       rs0;
      logic [7:0] byte1;
      logic       rs1;
   } job_type;

   // set-DDRAM command for a 7-bit address
   function automatic logic [7:0] ddram_cmd(input logic [6:0] addr);
      ddram_cmd = {1'b1, addr};
   endfunction

endpackage

`default_nettype wire

// ===== src/clnw_front.sv =====
// ----------------------------------------------------------------------------
// clnw_front: request classifier
// Holds the configuration registers and turns each request into a job of one
// or two bytes for the transfer queue; go-to on an unsupported line count
// yields no job.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [2:0]                         csr_index,
   input  wire logic [clnw_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   input  wire logic                               push,
   input  wire logic                               full,
   input  wire logic [1:0]                         req_action,
   input  wire logic [7:0]                         req_byte_value,
   input  wire logic [6:0]                         req_address_counter,
   input  wire logic [7:0]                         req_column,
   input  wire logic [1:0]                         req_row,
   output clnw_pkg::job_type                       job,
   output logic                                    job_write
);

   clnw_pkg::cfg_type cfg_ff;
   clnw_pkg::cfg_type cfg_in;

   logic [6:0] l1, l2, l3, l4, pos;
   logic [7:0] pos_w, end1, end2, end3, end4;
   logic [6:0] nl_target;
   logic       wrap_hit;
   logic [6:0] wrap_dest;
   logic       goto_ok;
   logic [6:0] goto_base;
   logic [7:0] goto_cmd;
   logic       lc1, lc2, lc4;

   // decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (clnw_pkg::csr_index_type'(csr_index))
            clnw_pkg::REG_LINE_COUNT:       cfg_in.line_count = csr_write_data[2:0];
            clnw_pkg::REG_CONTROLLER_KIND:  cfg_in.controller_kind = csr_write_data[0];
            clnw_pkg::REG_WRAP_ENABLE:      cfg_in.wrap_enable = csr_write_data[0];
            clnw_pkg::REG_FIRST_LINE_BASE:  cfg_in.first_line_base = csr_write_data[6:0];
            clnw_pkg::REG_SECOND_LINE_BASE: cfg_in.second_line_base = csr_write_data[6:0];
            clnw_pkg::REG_THIRD_LINE_BASE:  cfg_in.third_line_base = csr_write_data[6:0];
            clnw_pkg::REG_FOURTH_LINE_BASE: cfg_in.fourth_line_base = csr_write_data[6:0];
            clnw_pkg::REG_LINE_LENGTH:      cfg_in.line_length = csr_write_data[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_count       <= clnw_pkg::LINE_COUNT_RESET;
         cfg_ff.controller_kind  <= clnw_pkg::CONTROLLER_KIND_RESET;
         cfg_ff.wrap_enable      <= clnw_pkg::WRAP_ENABLE_RESET;
         cfg_ff.first_line_base  <= clnw_pkg::FIRST_LINE_BASE_RESET;
         cfg_ff.second_line_base <= clnw_pkg::SECOND_LINE_BASE_RESET;
         cfg_ff.third_line_base  <= clnw_pkg::THIRD_LINE_BASE_RESET;
         cfg_ff.fourth_line_base <= clnw_pkg::FOURTH_LINE_BASE_RESET;
         cfg_ff.line_length      <= clnw_pkg::LINE_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign l1  = cfg_ff.first_line_base;
   assign l2  = cfg_ff.second_line_base;
   assign l3  = cfg_ff.third_line_base;
   assign l4  = cfg_ff.fourth_line_base;
   assign pos = req_address_counter;
   assign lc1 = (cfg_ff.line_count == 3'd1);
   assign lc2 = (cfg_ff.line_count == 3'd2);
   assign lc4 = (cfg_ff.line_count == 3'd4);

   // line ends at full width, no wrap of the sum
   assign pos_w = {1'b0, pos};
   assign end1  = {1'b0, l1} + {1'b0, cfg_ff.line_length};
   assign end2  = {1'b0, l2} + {1'b0, cfg_ff.line_length};
   assign end3  = {1'b0, l3} + {1'b0, cfg_ff.line_length};
   assign end4  = {1'b0, l4} + {1'b0, cfg_ff.line_length};

   // start of the next line for a newline
   always_comb begin
      nl_target = 7'd0;
      if (lc2) begin
         nl_target = (pos < l2) ? l2 : l1;
      end else if (lc4) begin
         if (cfg_ff.controller_kind) begin
            if (pos < l2)      nl_target = l2;
            else if (pos < l3) nl_target = l3;
            else if (pos < l4) nl_target = l4;
            else               nl_target = l1;
         end else begin
            if (pos < l3)                    nl_target = l2;
            else if (pos >= l2 && pos < l4)  nl_target = l3;
            else if (pos >= l3 && pos < l2)  nl_target = l4;
            else                             nl_target = l1;
         end
      end
   end

   // line-end detection; first match in line order wins
   always_comb begin
      wrap_hit  = 1'b0;
      wrap_dest = l1;
      if (lc1) begin
         if (pos_w == end1) begin
            wrap_hit = 1'b1; wrap_dest = l1;
         end
      end else if (lc2) begin
         if (pos_w == end1) begin
            wrap_hit = 1'b1; wrap_dest = l2;
         end else if (pos_w == end2) begin
            wrap_hit = 1'b1; wrap_dest = l1;
         end
      end else if (lc4) begin
         if (pos_w == end1) begin
            wrap_hit = 1'b1; wrap_dest = l2;
         end else if (pos_w == end2) begin
            wrap_hit = 1'b1; wrap_dest = l3;
         end else if (pos_w == end3) begin
            wrap_hit = 1'b1; wrap_dest = l4;
         end else if (pos_w == end4) begin
            wrap_hit = 1'b1; wrap_dest = l1;
         end
      end
   end

   // go-to base by row
   always_comb begin
      goto_ok   = 1'b1;
      goto_base = l1;
      if (lc1) begin
         goto_base = l1;
      end else if (lc2) begin
         goto_base = (req_row == 2'd0) ? l1 : l2;
      end else if (lc4) begin
         case (req_row)
            2'd0:    goto_base = l1;
            2'd1:    goto_base = l2;
            2'd2:    goto_base = l3;
            default: goto_base = l4;
         endcase
      end else begin
         goto_ok = 1'b0;
      end
   end

   assign goto_cmd = 8'h80 + {1'b0, goto_base} + req_column;

   // build the job
   always_comb begin
      job.two   = 1'b0;
      job.byte0 = req_byte_value;
      job.rs0   = clnw_pkg::RS_DATA;
      job.byte1 = req_byte_value;
      job.rs1   = clnw_pkg::RS_DATA;
      job_write = push && !full;
      unique case (clnw_pkg::action_type'(req_action))
         clnw_pkg::ACT_PUT: begin
            if (req_byte_value == clnw_pkg::NEWLINE_CHAR) begin
               job.byte0 = clnw_pkg::ddram_cmd(nl_target);
               job.rs0   = clnw_pkg::RS_INSTR;
            end else if (cfg_ff.wrap_enable && wrap_hit) begin
               job.two   = 1'b1;
               job.byte0 = clnw_pkg::ddram_cmd(wrap_dest);
               job.rs0   = clnw_pkg::RS_INSTR;
            end
         end
         clnw_pkg::ACT_COMMAND: job.rs0 = clnw_pkg::RS_INSTR;
         clnw_pkg::ACT_DATA:    job.rs0 = clnw_pkg::RS_DATA;
         clnw_pkg::ACT_GOTO: begin
            job.byte0 = goto_cmd;
            job.rs0   = clnw_pkg::RS_INSTR;
            job_write = push && !full && goto_ok;
         end
         default: job.rs0 = clnw_pkg::RS_DATA;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/clnw_queue.sv =====
// ----------------------------------------------------------------------------
// clnw_queue: job queue between classifier and transfer sequencer
// A small register queue with a fill count; a read and a write may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_queue #(
   parameter int Depth = clnw_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire clnw_pkg::job_type wr_job,
   input  wire logic              rd_en,
   output clnw_pkg::job_type      rd_job,
   output logic                   not_empty,
   output logic                   full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

   clnw_pkg::job_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == DepthCnt);
   assign rd_job    = entry_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the written beat
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

`default_nettype wire

// ===== src/clnw_back.sv =====
// ----------------------------------------------------------------------------
// clnw_back: nibble transfer sequencer
// Splits the head job into 4-bit transfers, high nibble first, into a result
// register that the receiver drains with pop.
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire clnw_pkg::job_type head_job,
   input  wire logic              job_avail,
   output logic                   job_pop,
   output logic                   empty,
   input  wire logic              pop,
   output logic                   rsp_register_select,
   output logic [3:0]             rsp_nibble,
   output logic                   rsp_high_half,
   output logic                   rsp_last
);

   logic [1:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic       load;
   logic [7:0] cur_byte;
   logic       cur_rs;
   logic       cur_last;

   assign empty = !out_valid_ff;
   assign load  = job_avail && (!out_valid_ff || pop);

   // pick the current nibble of the head job
   always_comb begin
      cur_byte = step_ff[1] ? head_job.byte1 : head_job.byte0;
      cur_rs   = step_ff[1] ? head_job.rs1 : head_job.rs0;
      cur_last = head_job.two ? (step_ff == 2'd3) : (step_ff == 2'd1);
      job_pop  = load && cur_last;
      step_in  = step_ff;
      if (load) begin
         step_in = cur_last ? 2'd0 : step_ff + 2'd1;
      end
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the result beat until it is taken
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_register_select <= cur_rs;
         rsp_nibble          <= step_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
         rsp_high_half       <= !step_ff[0];
         rsp_last            <= cur_last;
      end
   end

   // a single-byte job never reaches the second byte
   a_single_steps: assert property (@(posedge clock) disable iff (reset)
      (job_avail && !head_job.two) |-> !step_ff[1])
      else $error("sequencer stepped past a single-byte job");

   // a job leaves the queue exactly when its last beat is loaded
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (rsp_last && out_valid_ff && step_ff == 2'd0))
      else $error("job popped without a last beat");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (empty && step_ff == 2'd0))
      else $error("result pending after reset");

   // a new item starts with a high nibble
   a_start_high: assert property (@(posedge clock) disable iff (reset)
      (load && step_ff == 2'd0) |=> rsp_high_half)
      else $error("item did not start with the high nibble");

endmodule

`default_nettype wire

// ===== src/char_lcd_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer: 4-bit character LCD write path
// Turns put, command, data and go-to requests into nibble transfers.
//
// Usage:
//   Requests enter on push/full; a beat is taken when push is high and full
//   is low. Transfers leave on empty/pop; the oldest transfer sits on the
//   rsp_ ports while empty is low and is taken when pop is high.
//   Registers are written through csr_write_enable/csr_index/csr_write_data
//   while the block is idle (the user's rule; the block does not enforce it);
//   a write takes effect at the next edge. Each request yields two transfers
//   (one byte) or four (set-DDRAM jump then a character); go-to on an
//   unsupported line count yields none. The first transfer of a request goes
//   through the job queue, then the output register. The sequencer emits one
//   nibble per cycle while pop is high, so a request costs two or four output
//   slots; that output register sets the rate. A job queue of QueueDepth
//   entries decouples the two sides: requests are still taken while the
//   receiver stalls until the queue fills, then full rises. Reset empties the
//   queue and output register and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer #(
   parameter int QueueDepth = clnw_pkg::QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [2:0]                          csr_index,
   input  wire logic [clnw_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [1:0]                          req_action,
   input  wire logic [7:0]                          req_byte_value,
   input  wire logic [6:0]                          req_address_counter,
   input  wire logic [7:0]                          req_column,
   input  wire logic [1:0]                          req_row,
   output logic                                     empty,
   input  wire logic                                pop,
   output logic                                     rsp_register_select,
   output logic [3:0]                               rsp_nibble,
   output logic                                     rsp_high_half,
   output logic                                     rsp_last
);

   clnw_pkg::job_type new_job;
   clnw_pkg::job_type head_job;
   logic              job_write;
   logic              job_pop;
   logic              job_avail;

   // classify requests
   clnw_front u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .push                (push),
      .full                (full),
      .req_action          (req_action),
      .req_byte_value      (req_byte_value),
      .req_address_counter (req_address_counter),
      .req_column          (req_column),
      .req_row             (req_row),
      .job                 (new_job),
      .job_write           (job_write)
   );

   // queue jobs
   clnw_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (job_write),
      .wr_job    (new_job),
      .rd_en     (job_pop),
      .rd_job    (head_job),
      .not_empty (job_avail),
      .full      (full)
   );

   // sequence nibbles
   clnw_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_job            (head_job),
      .job_avail           (job_avail),
      .job_pop             (job_pop),
      .empty               (empty),
      .pop                 (pop),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_high_half       (rsp_high_half),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sim/char_lcd_nibble_writer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_tb: self-checking bench for the LCD nibble writer
// Sends put, command, data and go-to requests under a series of register
// settings, works out the nibble transfers of every accepted request and
// compares each transfer beat with the oldest one still due.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_tb;

   localparam int STALL_LIMIT   = 1000;
   localparam int LONG_HOLD     = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 40;
   localparam int BURST_ITEMS   = 16;

   typedef struct packed {
      clnw_pkg::action_type action;
      logic [7:0]           byte_value;
      logic [6:0]           address_counter;
      logic [7:0]           column;
      logic [1:0]           row;
   } lcd_req_type;

   // bytes sent for one request, at most two
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte0;
      logic       rs0;
      logic [7:0] byte1;
      logic       rs1;
   } byte_plan_type;

   typedef struct packed {
      logic       register_select;
      logic [3:0] nibble;
      logic       high_half;
      logic       last;
   } transfer_type;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      clnw_pkg::csr_index_type reg_index;
      logic [6:0]              reg_value;
      lcd_req_type             req;
      logic                    typed;
      byte_plan_type           plan;
   } script_row_type;

   typedef logic [7:0][6:0] reg_image_type;

   localparam byte_plan_type NO_BYTES = '0;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_write_enable;
   logic [2:0]                          csr_index;
   logic [clnw_pkg::CSR_DATA_WIDTH-1:0] csr_write_data;
   logic                                push;
   logic                                full;
   logic [1:0]                          req_action;
   logic [7:0]                          req_byte_value;
   logic [6:0]                          req_address_counter;
   logic [7:0]                          req_column;
   logic [1:0]                          req_row;
   logic                                empty;
   logic                                pop;
   logic                                rsp_register_select;
   logic [3:0]                          rsp_nibble;
   logic                                rsp_high_half;
   logic                                rsp_last;

   // typed-in expectation that travels with the request on the bus
   logic          typed_pending;
   byte_plan_type typed_plan;

   clnw_pkg::cfg_type settings;
   transfer_type      nibbles_due[$];
   int                errors = 0;
   bit                steady;
   bit                sender_burst;
   bit                hold_off_request;

   char_lcd_nibble_writer u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .push                (push),
      .full                (full),
      .req_action          (req_action),
      .req_byte_value      (req_byte_value),
      .req_address_counter (req_address_counter),
      .req_column          (req_column),
      .req_row             (req_row),
      .empty               (empty),
      .pop                 (pop),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_high_half       (rsp_high_half),
      .rsp_last            (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic logic [7:0] ddram_byte(logic [6:0] addr, logic [7:0] col);
      logic [7:0] sum;
      sum = 8'h80 + 8'(addr) + col;
      return sum;
   endfunction

   function automatic byte_plan_type one_byte(logic [7:0] b, logic rs);
      return {2'd1, b, rs, 8'h00, clnw_pkg::RS_INSTR};
   endfunction

   // start of the line after the one holding pos
   function automatic logic [6:0] next_line_base(clnw_pkg::cfg_type c, logic [6:0] pos);
      if (c.line_count == 3'd2) begin
         return (pos < c.second_line_base) ? c.second_line_base : c.first_line_base;
      end
      if (c.line_count == 3'd4) begin
         if (c.controller_kind) begin
            if (pos < c.second_line_base) return c.second_line_base;
            if (pos < c.third_line_base) return c.third_line_base;
            if (pos < c.fourth_line_base) return c.fourth_line_base;
            return c.first_line_base;
         end
         if (pos < c.third_line_base) return c.second_line_base;
         if (pos >= c.second_line_base && pos < c.fourth_line_base) return c.third_line_base;
         if (pos >= c.third_line_base && pos < c.second_line_base) return c.fourth_line_base;
         return c.first_line_base;
      end
      return 7'd0;
   endfunction

   // line end match, summed at full width; first line in order wins
   function automatic bit line_end_jump(clnw_pkg::cfg_type c, logic [6:0] pos,
                                        output logic [6:0] target);
      logic [3:0][6:0] bases;
      int lines;
      bases  = {c.fourth_line_base, c.third_line_base, c.second_line_base,
                c.first_line_base};
      target = '0;
      lines  = 0;
      case (c.line_count)
         3'd1: lines = 1;
         3'd2: lines = 2;
         3'd4: lines = 4;
         default: lines = 0;
      endcase
      for (int i = 0; i < lines; i++) begin
         if (int'(pos) == int'(bases[i]) + int'(c.line_length)) begin
            target = bases[(i + 1) % lines];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic byte_plan_type predict_bytes(clnw_pkg::cfg_type c, lcd_req_type r);
      byte_plan_type   p;
      logic [6:0]      target;
      logic [3:0][6:0] bases;
      p     = NO_BYTES;
      bases = {c.fourth_line_base, c.third_line_base, c.second_line_base,
               c.first_line_base};
      case (r.action)
         clnw_pkg::ACT_PUT: begin
            if (r.byte_value == clnw_pkg::NEWLINE_CHAR) begin
               p = one_byte(ddram_byte(next_line_base(c, r.address_counter), 8'd0),
                            clnw_pkg::RS_INSTR);
            end else if (c.wrap_enable && line_end_jump(c, r.address_counter, target)) begin
               p = {2'd2, ddram_byte(target, 8'd0), clnw_pkg::RS_INSTR,
                    r.byte_value, clnw_pkg::RS_DATA};
            end else begin
               p = one_byte(r.byte_value, clnw_pkg::RS_DATA);
            end
         end
         clnw_pkg::ACT_COMMAND: p = one_byte(r.byte_value, clnw_pkg::RS_INSTR);
         clnw_pkg::ACT_DATA:    p = one_byte(r.byte_value, clnw_pkg::RS_DATA);
         default: begin
            case (c.line_count)
               3'd1: p = one_byte(ddram_byte(c.first_line_base, r.column),
                                  clnw_pkg::RS_INSTR);
               3'd2: p = one_byte(ddram_byte((r.row == 2'd0) ? c.first_line_base
                                             : c.second_line_base, r.column),
                                  clnw_pkg::RS_INSTR);
               3'd4: p = one_byte(ddram_byte(bases[r.row], r.column), clnw_pkg::RS_INSTR);
               default: p = NO_BYTES;
            endcase
         end
      endcase
      return p;
   endfunction

   // split each byte into high and low nibble beats
   function automatic void queue_transfers(byte_plan_type p);
      logic [1:0][7:0] bytes;
      logic [1:0]      rs;
      bytes = {p.byte1, p.byte0};
      rs    = {p.rs1, p.rs0};
      for (int i = 0; i < int'(p.count); i++) begin
         nibbles_due.push_back({rs[i], bytes[i][7:4], 1'b1, 1'b0});
         nibbles_due.push_back({rs[i], bytes[i][3:0], 1'b0, i == int'(p.count) - 1});
      end
   endfunction

   function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: track register writes, predict on accepted requests, check beats
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      transfer_type  want;
      byte_plan_type plan;
      if (reset) begin
         settings = {clnw_pkg::LINE_COUNT_RESET, clnw_pkg::CONTROLLER_KIND_RESET,
                     clnw_pkg::WRAP_ENABLE_RESET, clnw_pkg::FIRST_LINE_BASE_RESET,
                     clnw_pkg::SECOND_LINE_BASE_RESET, clnw_pkg::THIRD_LINE_BASE_RESET,
                     clnw_pkg::FOURTH_LINE_BASE_RESET, clnw_pkg::LINE_LENGTH_RESET};
      end else begin
         if (csr_write_enable) begin
            case (clnw_pkg::csr_index_type'(csr_index))
               clnw_pkg::REG_LINE_COUNT:
                  settings.line_count = csr_write_data[2:0];
               clnw_pkg::REG_CONTROLLER_KIND:
                  settings.controller_kind = csr_write_data[0];
               clnw_pkg::REG_WRAP_ENABLE:
                  settings.wrap_enable = csr_write_data[0];
               clnw_pkg::REG_FIRST_LINE_BASE:
                  settings.first_line_base = csr_write_data;
               clnw_pkg::REG_SECOND_LINE_BASE:
                  settings.second_line_base = csr_write_data;
               clnw_pkg::REG_THIRD_LINE_BASE:
                  settings.third_line_base = csr_write_data;
               clnw_pkg::REG_FOURTH_LINE_BASE:
                  settings.fourth_line_base = csr_write_data;
               clnw_pkg::REG_LINE_LENGTH:
                  settings.line_length = csr_write_data;
               default: ;
            endcase
         end
         if (push && !full) begin
            plan = typed_pending ? typed_plan
                 : predict_bytes(settings, {clnw_pkg::action_type'(req_action),
                                            req_byte_value, req_address_counter,
                                            req_column, req_row});
            queue_transfers(plan);
         end
         if (pop && !empty) begin
            if (nibbles_due.size() == 0) begin
               errors++;
               $display("%0t: transfer rs=%0h nibble=%0h high=%0h last=%0h with none due",
                        $time, rsp_register_select, rsp_nibble, rsp_high_half, rsp_last);
            end else begin
               want = nibbles_due.pop_front();
               check_field("register_select", 4'(want.register_select),
                           4'(rsp_register_select));
               check_field("nibble", want.nibble, rsp_nibble);
               check_field("high_half", 4'(want.high_half), 4'(rsp_high_half));
               check_field("last", 4'(want.last), 4'(rsp_last));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Pacing
   // ------------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin : drain_side
      int stall_left;
      bit held;
      stall_left = 0;
      held       = 1'b0;
      pop        = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !held) begin
            held = 1'b1;
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // end the run when nothing moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty) || csr_write_enable)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic send_request(lcd_req_type r, logic typed, byte_plan_type plan);
      int gap;
      gap = sender_burst ? 0 : pick_gap();
      csr_write_enable <= 1'b0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push                <= 1'b1;
      req_action          <= r.action;
      req_byte_value      <= r.byte_value;
      req_address_counter <= r.address_counter;
      req_column          <= r.column;
      req_row             <= r.row;
      typed_pending       <= typed;
      typed_plan          <= plan;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // drop push, drain every due beat, then let the block settle
   task automatic wait_idle();
      push             <= 1'b0;
      csr_write_enable <= 1'b0;
      @(posedge clock);
      while (nibbles_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(clnw_pkg::csr_index_type idx, logic [6:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   function automatic script_row_type ask(clnw_pkg::action_type a, logic [7:0] b,
                                          logic [6:0] ac, logic [7:0] col,
                                          logic [1:0] rw);
      script_row_type s;
      s      = '0;
      s.kind = ROW_REQ;
      s.req  = {a, b, ac, col, rw};
      return s;
   endfunction

   function automatic script_row_type ask_typed(clnw_pkg::action_type a, logic [7:0] b,
                                                logic [6:0] ac, logic [7:0] col,
                                                logic [1:0] rw, byte_plan_type p);
      script_row_type s;
      s       = ask(a, b, ac, col, rw);
      s.typed = 1'b1;
      s.plan  = p;
      return s;
   endfunction

   function automatic script_row_type set_reg(clnw_pkg::csr_index_type idx,
                                              logic [6:0] value);
      script_row_type s;
      s           = '0;
      s.kind      = ROW_CFG;
      s.reg_index = idx;
      s.reg_value = value;
      return s;
   endfunction

   // settings per phase: minimum, maximum, each line layout, no lines, then random
   function automatic reg_image_type pick_settings(int phase);
      reg_image_type v;
      v[clnw_pkg::REG_LINE_COUNT]       = 7'($urandom_range(0, 7));
      v[clnw_pkg::REG_CONTROLLER_KIND]  = 7'($urandom_range(0, 1));
      v[clnw_pkg::REG_WRAP_ENABLE]      = 7'd1;
      v[clnw_pkg::REG_FIRST_LINE_BASE]  = 7'($urandom);
      v[clnw_pkg::REG_SECOND_LINE_BASE] = 7'($urandom);
      v[clnw_pkg::REG_THIRD_LINE_BASE]  = 7'($urandom);
      v[clnw_pkg::REG_FOURTH_LINE_BASE] = 7'($urandom);
      v[clnw_pkg::REG_LINE_LENGTH]      = 7'($urandom_range(1, 40));
      case (phase)
         0: begin
            v = '0;
            v[clnw_pkg::REG_LINE_COUNT]  = 7'd1;
            v[clnw_pkg::REG_WRAP_ENABLE] = 7'd1;
         end
         1: begin
            v = '1;
            v[clnw_pkg::REG_CONTROLLER_KIND] = 7'd1;
            v[clnw_pkg::REG_WRAP_ENABLE]     = 7'd1;
            v[clnw_pkg::REG_LINE_COUNT]      = 7'd7;
         end
         2: v[clnw_pkg::REG_LINE_COUNT] = 7'd2;
         3: begin
            v[clnw_pkg::REG_LINE_COUNT]      = 7'd4;
            v[clnw_pkg::REG_CONTROLLER_KIND] = 7'd0;
         end
         4: begin
            v[clnw_pkg::REG_LINE_COUNT]      = 7'd4;
            v[clnw_pkg::REG_CONTROLLER_KIND] = 7'd1;
         end
         5: begin
            v[clnw_pkg::REG_LINE_COUNT]  = 7'd4;
            v[clnw_pkg::REG_WRAP_ENABLE] = 7'd0;
         end
         6: v[clnw_pkg::REG_LINE_COUNT] = 7'd0;
         default: ;
      endcase
      return v;
   endfunction

   // bias the address counter toward line starts and line ends
   function automatic lcd_req_type random_request();
      lcd_req_type     r;
      logic [3:0][6:0] bases;
      int              pick;
      int              line;
      bases = {settings.fourth_line_base, settings.third_line_base,
               settings.second_line_base, settings.first_line_base};
      line  = $urandom_range(0, 3);
      case ($urandom_range(0, 4))
         0, 1:    r.action = clnw_pkg::ACT_PUT;
         2:       r.action = clnw_pkg::ACT_COMMAND;
         3:       r.action = clnw_pkg::ACT_DATA;
         default: r.action = clnw_pkg::ACT_GOTO;
      endcase
      r.byte_value = ($urandom_range(0, 3) == 0) ? clnw_pkg::NEWLINE_CHAR : 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 4)
         r.address_counter = bases[line] + settings.line_length;
      else if (pick < 6)
         r.address_counter = bases[line] - 7'($urandom_range(0, 1));
      else
         r.address_counter = 7'($urandom);
      pick = $urandom_range(0, 5);
      r.column = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      r.row    = 2'($urandom);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      script_row_type script[$];
      reg_image_type  image;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = clnw_pkg::REG_LINE_COUNT;
      csr_write_data      = '0;
      push                = 1'b0;
      req_action          = clnw_pkg::ACT_PUT;
      req_byte_value      = '0;
      req_address_counter = '0;
      req_column          = '0;
      req_row             = '0;
      typed_pending       = 1'b0;
      typed_plan          = NO_BYTES;
      steady              = 1'b0;
      sender_burst        = 1'b0;
      hold_off_request    = 1'b0;

      // reset settings: two lines, bases 0/64/20/84, length 20, wrap off
      script.push_back(ask_typed(clnw_pkg::ACT_PUT, 8'h41, 7'd0, 8'd0, 2'd0,
                                 one_byte(8'h41, clnw_pkg::RS_DATA)));
      script.push_back(ask_typed(clnw_pkg::ACT_PUT, 8'h00, 7'd0, 8'd0, 2'd0,
                                 one_byte(8'h00, clnw_pkg::RS_DATA)));
      script.push_back(ask_typed(clnw_pkg::ACT_PUT, 8'hFF, 7'd127, 8'd255, 2'd3,
                                 one_byte(8'hFF, clnw_pkg::RS_DATA)));
      script.push_back(ask_typed(clnw_pkg::ACT_COMMAND, 8'h00, 7'd0, 8'd0, 2'd0,
                                 one_byte(8'h00, clnw_pkg::RS_INSTR)));
      script.push_back(ask_typed(clnw_pkg::ACT_COMMAND, 8'hFF, 7'd0, 8'd0, 2'd0,
                                 one_byte(8'hFF, clnw_pkg::RS_INSTR)));
      script.push_back(ask_typed(clnw_pkg::ACT_DATA, 8'hA5, 7'd0, 8'd0, 2'd0,
                                 one_byte(8'hA5, clnw_pkg::RS_DATA)));
      // newline as a data byte is plain data
      script.push_back(ask_typed(clnw_pkg::ACT_DATA, clnw_pkg::NEWLINE_CHAR, 7'd0, 8'd0,
                                 2'd0, one_byte(clnw_pkg::NEWLINE_CHAR, clnw_pkg::RS_DATA)));
      // newline from line one goes to line two, from line two back to line one
      script.push_back(ask_typed(clnw_pkg::ACT_PUT, clnw_pkg::NEWLINE_CHAR, 7'd10, 8'd0,
                                 2'd0, one_byte(8'hC0, clnw_pkg::RS_INSTR)));
      script.push_back(ask_typed(clnw_pkg::ACT_PUT, clnw_pkg::NEWLINE_CHAR, 7'd127, 8'd0,
                                 2'd0, one_byte(8'h80, clnw_pkg::RS_INSTR)));
      script.push_back(ask_typed(clnw_pkg::ACT_GOTO, 8'h00, 7'd0, 8'd0, 2'd0,
                                 one_byte(8'h80, clnw_pkg::RS_INSTR)));
      // go-to address sum wraps at 8 bits
      script.push_back(ask_typed(clnw_pkg::ACT_GOTO, 8'h00, 7'd0, 8'd255, 2'd3,
                                 one_byte(8'hBF, clnw_pkg::RS_INSTR)));
      script.push_back(ask(clnw_pkg::ACT_GOTO, 8'h00, 7'd0, 8'd5, 2'd1));
      script.push_back(ask(clnw_pkg::ACT_PUT, 8'h78, 7'd20, 8'd0, 2'd0));
      // wrap at the end of line one and of line two
      script.push_back(set_reg(clnw_pkg::REG_WRAP_ENABLE, 7'd1));
      script.push_back(ask(clnw_pkg::ACT_PUT, 8'h78, 7'd20, 8'd0, 2'd0));
      script.push_back(ask(clnw_pkg::ACT_PUT, 8'h79, 7'd84, 8'd0, 2'd0));
      // four lines, standard order
      script.push_back(set_reg(clnw_pkg::REG_LINE_COUNT, 7'd4));
      script.push_back(ask(clnw_pkg::ACT_PUT, 8'h7A, 7'd104, 8'd0, 2'd0));
      script.push_back(ask(clnw_pkg::ACT_PUT, clnw_pkg::NEWLINE_CHAR, 7'd30, 8'd0, 2'd0));
      script.push_back(ask(clnw_pkg::ACT_GOTO, 8'h00, 7'd0, 8'd1, 2'd2));
      // four lines, sequential order
      script.push_back(set_reg(clnw_pkg::REG_CONTROLLER_KIND, 7'd1));
      script.push_back(ask(clnw_pkg::ACT_PUT, clnw_pkg::NEWLINE_CHAR, 7'd70, 8'd0, 2'd0));
      script.push_back(ask(clnw_pkg::ACT_PUT, clnw_pkg::NEWLINE_CHAR, 7'd100, 8'd0, 2'd0));
      // one line
      script.push_back(set_reg(clnw_pkg::REG_LINE_COUNT, 7'd1));
      script.push_back(ask(clnw_pkg::ACT_GOTO, 8'h00, 7'd0, 8'd7, 2'd3));
      script.push_back(ask(clnw_pkg::ACT_PUT, clnw_pkg::NEWLINE_CHAR, 7'd50, 8'd0, 2'd0));
      script.push_back(ask(clnw_pkg::ACT_PUT, 8'h77, 7'd20, 8'd0, 2'd0));
      // unsupported line count: go-to sends nothing, newline goes home
      script.push_back(set_reg(clnw_pkg::REG_LINE_COUNT, 7'd3));
      script.push_back(ask_typed(clnw_pkg::ACT_GOTO, 8'h00, 7'd0, 8'd3, 2'd1, NO_BYTES));
      script.push_back(ask_typed(clnw_pkg::ACT_PUT, clnw_pkg::NEWLINE_CHAR, 7'd50, 8'd0,
                                 2'd0, one_byte(8'h80, clnw_pkg::RS_INSTR)));
      script.push_back(ask(clnw_pkg::ACT_PUT, 8'h76, 7'd20, 8'd0, 2'd0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed script
      foreach (script[i]) begin
         if (script[i].kind == ROW_CFG) begin
            wait_idle();
            write_reg(script[i].reg_index, script[i].reg_value);
         end else begin
            send_request(script[i].req, script[i].typed, script[i].plan);
         end
      end

      // random phases, each under fresh settings
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         image = pick_settings(phase);
         for (int k = 0; k < 8; k++) write_reg(clnw_pkg::csr_index_type'(k), image[k]);
         steady = (phase == 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // fill the block while the receiver holds off
            if (phase == 2 && k == 0) begin
               hold_off_request = 1'b1;
               sender_burst     = 1'b1;
            end
            if (phase == 2 && k == BURST_ITEMS) sender_burst = 1'b0;
            // pause until every due beat is out
            if (phase == 5 && k == PHASE_ITEMS / 2) wait_idle();
            send_request(random_request(), 1'b0, NO_BYTES);
         end
      end
      steady = 1'b0;
      wait_idle();

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/clnw_pkg.sv
src/clnw_front.sv
src/clnw_queue.sv
src/clnw_back.sv
src/char_lcd_nibble_writer.sv
sim/char_lcd_nibble_writer_tb.sv
